>>> sv/ira_pkg.sv
// ---------------------------------------------------------------------------
// ira_pkg: shared types and constants of the I2C register access master
// Word layouts, configuration register indexes and the bus sequencer phases.
// ---------------------------------------------------------------------------
`default_nettype none

package ira_pkg;

  // Divider width default
  localparam int DIVIDER_BITS_DEF = 16;

  // Configuration register indexes
  localparam logic CFG_DEVICE_ADDR = 1'b0;
  localparam logic CFG_HALF_PERIOD = 1'b1;

  // Configuration reset values
  localparam logic [7:0]  DEVICE_ADDR_RST = 8'd144;
  localparam logic [15:0] HALF_PERIOD_RST = 16'd100;

  // Byte constants
  localparam logic [7:0] ADDR_MASK = 8'hfe;
  localparam logic [7:0] READ_BIT  = 8'h01;
  localparam logic [7:0] FILL_BYTE = 8'hff;
  localparam logic [7:0] MSB_MASK  = 8'h80;

  // Bus sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE        = 5'd0,
    PH_START_LOW   = 5'd1,
    PH_START_SETUP = 5'd2,
    PH_START_HOLD  = 5'd3,
    PH_BIT_LOW     = 5'd4,
    PH_BIT_HIGH    = 5'd5,
    PH_STOP_LOW    = 5'd6,
    PH_STOP_HIGH   = 5'd7,
    PH_STOP_END    = 5'd8
  } phase_t;

  // One input word (one tick)
  typedef struct packed {
    logic        command_valid;
    logic        func;
    logic [7:0]  register_pointer;
    logic [15:0] write_word;
    logic        sda_sample;
  } in_item_t;

  // One result word
  typedef struct packed {
    logic        scl_level;
    logic        sda_pull_low;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_word;
    logic [2:0]  ack_failures;
  } out_item_t;

  // Configuration register contents
  typedef struct packed {
    logic [7:0]  device_address_byte;
    logic [15:0] half_period_ticks;
  } cfg_t;

endpackage

`default_nettype wire

>>> sv/ira_if.sv
// ---------------------------------------------------------------------------
// ira_if: valid/ready channels of the I2C register access master
// Input tick channel and result channel, each with source and sink views.
// ---------------------------------------------------------------------------
`default_nettype none

interface ira_in_if;
  logic        valid;
  logic        ready;
  logic        command_valid;
  logic        func;
  logic [7:0]  register_pointer;
  logic [15:0] write_word;
  logic        sda_sample;

  modport source (
    output valid, command_valid, func, register_pointer, write_word, sda_sample,
    input  ready
  );
  modport sink (
    input  valid, command_valid, func, register_pointer, write_word, sda_sample,
    output ready
  );
endinterface

interface ira_out_if;
  logic        valid;
  logic        ready;
  logic        scl_level;
  logic        sda_pull_low;
  logic        busy_res;
  logic        done_res;
  logic [15:0] read_word;
  logic [2:0]  ack_failures;

  modport source (
    output valid, scl_level, sda_pull_low, busy_res, done_res, read_word, ack_failures,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_pull_low, busy_res, done_res, read_word, ack_failures,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/ira_seq.sv
// ---------------------------------------------------------------------------
// ira_seq: bus sequencer of the I2C register access master
// Holds the transaction state and works out one tick per step: divider,
// phase advance, bit shifting, acknowledge sampling and the result word.
// ---------------------------------------------------------------------------
`default_nettype none

module ira_seq #(
  parameter int DIVIDER_BITS = ira_pkg::DIVIDER_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire ira_pkg::in_item_t  item,
  input  wire ira_pkg::cfg_t      cfg,
  output ira_pkg::out_item_t      res
);

  localparam int HW = (DIVIDER_BITS > 16) ? DIVIDER_BITS : 16;

  // Sequencer state
  ira_pkg::phase_t         phase_r, phase_nxt;
  logic [2:0]              byte_step_r, byte_step_nxt;
  logic [3:0]              bit_count_r, bit_count_nxt;
  logic [7:0]              shift_byte_r, shift_byte_nxt;
  logic [DIVIDER_BITS-1:0] div_r, div_nxt;
  logic                    func_r, func_nxt;
  logic [7:0]              ptr_r, ptr_nxt;
  logic [15:0]             word_r, word_nxt;
  logic [15:0]             gathered_r, gathered_nxt;
  logic [2:0]              fail_r, fail_nxt;
  logic                    scl_r, scl_nxt;
  logic                    pull_r, pull_nxt;

  logic [HW-1:0]           half_ext;
  logic [HW-1:0]           dmask_ext;
  logic [HW-1:0]           half_sat;
  logic [DIVIDER_BITS-1:0] half_db;
  logic [DIVIDER_BITS-1:0] div_inc;
  logic                    done;
  logic                    load_next;

  // Byte to send at a given byte step
  function automatic logic [7:0] load_byte(input logic rd, input logic [2:0] bstep,
                                           input logic [7:0] addr, input logic [7:0] ptr,
                                           input logic [15:0] word);
    logic [7:0] a;
    a = addr & ira_pkg::ADDR_MASK;
    if (bstep == 3'd0)      return a;
    else if (bstep == 3'd1) return ptr;
    else if (rd)            return (bstep == 3'd2) ? (a | ira_pkg::READ_BIT)
                                                   : ira_pkg::FILL_BYTE;
    else if (bstep == 3'd2) return word[15:8];
    else                    return word[7:0];
  endfunction

  // SDA pull for the current bit slot
  function automatic logic bit_pull(input logic rd, input logic [2:0] bstep,
                                    input logic [3:0] bcnt, input logic [7:0] sbyte);
    logic reading;
    reading = rd && (bstep >= 3'd3);
    if (bcnt < 4'd8) return reading ? 1'b0 : ((sbyte & ira_pkg::MSB_MASK) == 8'd0);
    else             return reading ? (bstep == 3'd3) : 1'b0;
  endfunction

  // Clamp the half period to the divider range, zero counts as one
  assign half_ext  = HW'(cfg.half_period_ticks);
  assign dmask_ext = HW'({DIVIDER_BITS{1'b1}});
  assign half_sat  = (half_ext > dmask_ext) ? dmask_ext : half_ext;
  assign half_db   = (half_sat == '0) ? DIVIDER_BITS'(1) : half_sat[DIVIDER_BITS-1:0];
  assign div_inc   = div_r + DIVIDER_BITS'(1);

  // Next state and result of one tick
  always_comb begin
    phase_nxt      = phase_r;
    byte_step_nxt  = byte_step_r;
    bit_count_nxt  = bit_count_r;
    shift_byte_nxt = shift_byte_r;
    div_nxt        = div_r;
    func_nxt       = func_r;
    ptr_nxt        = ptr_r;
    word_nxt       = word_r;
    gathered_nxt   = gathered_r;
    fail_nxt       = fail_r;
    scl_nxt        = scl_r;
    pull_nxt       = pull_r;
    done           = 1'b0;
    load_next      = 1'b0;

    if (phase_r == ira_pkg::PH_IDLE) begin
      if (item.command_valid) begin
        func_nxt       = item.func;
        ptr_nxt        = item.register_pointer;
        word_nxt       = item.write_word;
        byte_step_nxt  = 3'd0;
        bit_count_nxt  = 4'd0;
        shift_byte_nxt = 8'd0;
        gathered_nxt   = 16'd0;
        fail_nxt       = 3'd0;
        div_nxt        = '0;
        phase_nxt      = ira_pkg::PH_START_LOW;
        scl_nxt        = 1'b0;
        pull_nxt       = 1'b0;
      end
    end else begin
      div_nxt = div_inc;
      if (div_inc >= half_db) begin
        div_nxt = '0;
        unique case (phase_r)
          ira_pkg::PH_START_LOW: begin
            phase_nxt = ira_pkg::PH_START_SETUP;
            scl_nxt   = 1'b1;
            pull_nxt  = 1'b0;
          end
          ira_pkg::PH_START_SETUP: begin
            phase_nxt = ira_pkg::PH_START_HOLD;
            scl_nxt   = 1'b1;
            pull_nxt  = 1'b1;
          end
          ira_pkg::PH_START_HOLD: begin
            load_next = 1'b1;
          end
          ira_pkg::PH_BIT_LOW: begin
            phase_nxt = ira_pkg::PH_BIT_HIGH;
            scl_nxt   = 1'b1;
            pull_nxt  = bit_pull(func_r, byte_step_r, bit_count_r, shift_byte_r);
          end
          ira_pkg::PH_BIT_HIGH: begin
            if (bit_count_r < 4'd8) begin
              // shift in a read bit, advance to the next bit slot
              if (func_r && (byte_step_r >= 3'd3)) begin
                gathered_nxt = {gathered_r[14:0], item.sda_sample};
              end
              shift_byte_nxt = {shift_byte_r[6:0], 1'b0};
              bit_count_nxt  = bit_count_r + 4'd1;
              phase_nxt      = ira_pkg::PH_BIT_LOW;
              scl_nxt        = 1'b0;
              pull_nxt       = bit_pull(func_r, byte_step_r, bit_count_nxt, shift_byte_nxt);
            end else begin
              // acknowledge slot: count a missing ACK, pick the next byte
              if (!(func_r && (byte_step_r >= 3'd3)) && item.sda_sample &&
                  (fail_r != 3'd7)) begin
                fail_nxt = fail_r + 3'd1;
              end
              byte_step_nxt = byte_step_r + 3'd1;
              if (func_r && (byte_step_nxt == 3'd2)) begin
                phase_nxt = ira_pkg::PH_START_LOW;
                scl_nxt   = 1'b0;
                pull_nxt  = 1'b0;
              end else if (byte_step_nxt >= (func_r ? 3'd5 : 3'd4)) begin
                phase_nxt = ira_pkg::PH_STOP_LOW;
                scl_nxt   = 1'b0;
                pull_nxt  = 1'b1;
              end else begin
                load_next = 1'b1;
              end
            end
          end
          ira_pkg::PH_STOP_LOW: begin
            phase_nxt = ira_pkg::PH_STOP_HIGH;
            scl_nxt   = 1'b1;
            pull_nxt  = 1'b1;
          end
          ira_pkg::PH_STOP_HIGH: begin
            phase_nxt = ira_pkg::PH_STOP_END;
            scl_nxt   = 1'b1;
            pull_nxt  = 1'b0;
          end
          default: begin
            phase_nxt = ira_pkg::PH_IDLE;
            scl_nxt   = 1'b1;
            pull_nxt  = 1'b0;
            done      = 1'b1;
          end
        endcase

        // load the next byte into the shifter
        if (load_next) begin
          shift_byte_nxt = load_byte(func_r, byte_step_nxt, cfg.device_address_byte,
                                     ptr_r, word_r);
          bit_count_nxt  = 4'd0;
          phase_nxt      = ira_pkg::PH_BIT_LOW;
          scl_nxt        = 1'b0;
          pull_nxt       = bit_pull(func_r, byte_step_nxt, 4'd0, shift_byte_nxt);
        end
      end
    end

    res.scl_level    = scl_nxt;
    res.sda_pull_low = pull_nxt;
    res.busy_res     = (phase_nxt != ira_pkg::PH_IDLE);
    res.done_res     = done;
    res.read_word    = done ? gathered_nxt : 16'd0;
    res.ack_failures = done ? fail_nxt : 3'd0;
  end

  // Advance the state once per processed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ira_pkg::PH_IDLE;
      byte_step_r  <= 3'd0;
      bit_count_r  <= 4'd0;
      shift_byte_r <= 8'd0;
      div_r        <= '0;
      func_r       <= 1'b0;
      ptr_r        <= 8'd0;
      word_r       <= 16'd0;
      gathered_r   <= 16'd0;
      fail_r       <= 3'd0;
      scl_r        <= 1'b1;
      pull_r       <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      byte_step_r  <= byte_step_nxt;
      bit_count_r  <= bit_count_nxt;
      shift_byte_r <= shift_byte_nxt;
      div_r        <= div_nxt;
      func_r       <= func_nxt;
      ptr_r        <= ptr_nxt;
      word_r       <= word_nxt;
      gathered_r   <= gathered_nxt;
      fail_r       <= fail_nxt;
      scl_r        <= scl_nxt;
      pull_r       <= pull_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/i2c_register_access_master.sv
// An accepted word goes from the input register through the sequencer to the
// result register. Throughput: one tick word per cycle while the result
// channel takes words; the input register and the result register let a new
// word enter while the previous result waits.
// Reset (synchronous, rst_n low): sequencer idle, SCL high, SDA released,
// both registers empty, device address 144, half period 100 ticks.
// ---------------------------------------------------------------------------
// i2c_register_access_master: tick-driven I2C master for 16-bit registers
// Input register, bus sequencer and result register, plus the config port.
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_register_access_master #(
  parameter int DIVIDER_BITS = ira_pkg::DIVIDER_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ira_in_if.sink           in_ch,
  ira_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  logic                in_v_r;
  ira_pkg::in_item_t   in_item_r;
  logic                out_v_r;
  ira_pkg::out_item_t  out_item_r;
  ira_pkg::out_item_t  seq_res;
  ira_pkg::cfg_t       cfg_r;
  logic                advance;
  logic                in_take;

  // Move a word from the input register to the result register
  assign advance  = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;
  assign in_take  = in_ch.valid && in_ch.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address_byte <= ira_pkg::DEVICE_ADDR_RST;
      cfg_r.half_period_ticks   <= ira_pkg::HALF_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ira_pkg::CFG_DEVICE_ADDR: cfg_r.device_address_byte <= cfg_wdata[7:0];
        ira_pkg::CFG_HALF_PERIOD: cfg_r.half_period_ticks   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  // Input register: payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.command_valid    <= in_ch.command_valid;
      in_item_r.func             <= in_ch.func;
      in_item_r.register_pointer <= in_ch.register_pointer;
      in_item_r.write_word       <= in_ch.write_word;
      in_item_r.sda_sample       <= in_ch.sda_sample;
    end
  end

  ira_seq #(
    .DIVIDER_BITS (DIVIDER_BITS)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .res   (seq_res)
  );

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= seq_res;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.scl_level    = out_item_r.scl_level;
  assign out_ch.sda_pull_low = out_item_r.sda_pull_low;
  assign out_ch.busy_res     = out_item_r.busy_res;
  assign out_ch.done_res     = out_item_r.done_res;
  assign out_ch.read_word    = out_item_r.read_word;
  assign out_ch.ack_failures = out_item_r.ack_failures;

`ifndef SYNTHESIS
  // a completed transaction is never reported as still busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_item_r.done_res) |-> !out_item_r.busy_res)
    else $error("done word reports busy");

  // an empty input register always takes a word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_v_r |-> in_ch.ready)
    else $error("input stalled while empty");

  // a processed tick always lands in the result register
  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("processed tick lost");

  // at most four bytes can miss their acknowledge
  a_fail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_item_r.done_res) |-> (out_item_r.ack_failures <= 3'd4))
    else $error("ack failure count out of range");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench of the I2C register access master
// Feeds one tick word per handshake, predicts the driven bus lines, busy,
// done, read word and acknowledge failure count for every tick, and compares
// each result word with the oldest prediction under random idling on both
// channels and several configurations, including mid-transfer changes.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

  // Directed step kinds
  typedef enum logic [1:0] {
    ROW_TICK = 2'd0,
    ROW_RUN  = 2'd1,
    ROW_CFG  = 2'd2
  } row_kind_t;

  // How the simulated device answers on SDA during one transfer
  typedef enum logic [1:0] {
    SDA_ACK_ALL    = 2'd0,
    SDA_SILENT     = 2'd1,
    SDA_NOISE      = 2'd2,
    SDA_MOSTLY_ACK = 2'd3
  } sda_habit_t;

  typedef struct packed {
    row_kind_t          kind;
    ira_pkg::in_item_t  tick;
    logic               reg_sel;
    logic [15:0]        reg_val;
    logic               typed;
    ira_pkg::out_item_t lines;
  } row_t;

  localparam logic SEL_ADDR = ira_pkg::CFG_DEVICE_ADDR;
  localparam logic SEL_HALF = ira_pkg::CFG_HALF_PERIOD;

  localparam ira_pkg::in_item_t  NO_TICK     = '0;
  localparam ira_pkg::out_item_t NO_LINES    = '0;
  localparam ira_pkg::out_item_t IDLE_LINES  = '{1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 3'd0};
  localparam ira_pkg::out_item_t START_LINES = '{1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 3'd0};

  // Directed script: reset state, field extremes, a write started at the
  // reset half period and sped up mid-transfer, command while busy, a read,
  // zero half period with the top address and a silent device
  localparam row_t SCRIPT [10] = '{
    '{ROW_TICK, '{1'b0, 1'b0, 8'h00, 16'h0000, 1'b0}, SEL_ADDR, 16'h0, 1'b1, IDLE_LINES},
    '{ROW_TICK, '{1'b0, 1'b1, 8'hff, 16'hffff, 1'b1}, SEL_ADDR, 16'h0, 1'b1, IDLE_LINES},
    '{ROW_TICK, '{1'b1, 1'b0, 8'h5a, 16'ha55a, 1'b0}, SEL_ADDR, 16'h0, 1'b1, START_LINES},
    '{ROW_TICK, '{1'b1, 1'b1, 8'hff, 16'hffff, 1'b0}, SEL_ADDR, 16'h0, 1'b1, START_LINES},
    '{ROW_CFG,  NO_TICK, SEL_HALF, 16'd1, 1'b0, NO_LINES},
    '{ROW_RUN,  '{1'b0, 1'b0, 8'h00, 16'h0000, 1'b0}, SEL_ADDR, 16'h0, 1'b0, NO_LINES},
    '{ROW_RUN,  '{1'b1, 1'b1, 8'h81, 16'h0000, 1'b0}, SEL_ADDR, 16'h0, 1'b1, START_LINES},
    '{ROW_CFG,  NO_TICK, SEL_HALF, 16'd0, 1'b0, NO_LINES},
    '{ROW_CFG,  NO_TICK, SEL_ADDR, 16'd254, 1'b0, NO_LINES},
    '{ROW_RUN,  '{1'b1, 1'b0, 8'hff, 16'hffff, 1'b1}, SEL_ADDR, 16'h0, 1'b1, START_LINES}
  };

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              tick_valid  = 1'b0;
  ira_pkg::in_item_t tick_word   = '0;
  logic              take_result = 1'b0;
  logic              cfg_we      = 1'b0;
  logic              cfg_index   = SEL_ADDR;
  logic [15:0]       cfg_wdata   = '0;
  logic              steady      = 1'b0;

  // Predicted device configuration and sequencer state
  logic [7:0]       dev_addr   = ira_pkg::DEVICE_ADDR_RST;
  logic [15:0]      half_ticks = ira_pkg::HALF_PERIOD_RST;
  ira_pkg::phase_t  seq_phase  = ira_pkg::PH_IDLE;
  logic [2:0]       byte_step  = '0;
  logic [3:0]       bit_cnt    = '0;
  logic [7:0]       shifter    = '0;
  logic [15:0]      divider    = '0;
  logic [24:0]      held       = '0;
  logic [15:0]      gathered   = '0;
  logic [2:0]       fails      = '0;
  logic             scl_out    = 1'b1;
  logic             pull_out   = 1'b0;

  ira_pkg::out_item_t expected_lines [$];
  int                 bus_faults = 0;

  ira_in_if  in_ch ();
  ira_out_if out_ch ();

  assign in_ch.valid            = tick_valid;
  assign in_ch.command_valid    = tick_word.command_valid;
  assign in_ch.func             = tick_word.func;
  assign in_ch.register_pointer = tick_word.register_pointer;
  assign in_ch.write_word       = tick_word.write_word;
  assign in_ch.sda_sample       = tick_word.sda_sample;
  assign out_ch.ready           = take_result;

  i2c_register_access_master dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---- sequencer prediction ----

  function automatic void drive_lines(input logic scl, input logic pull);
    scl_out  = scl;
    pull_out = pull;
  endfunction

  function automatic logic reading_byte();
    return held[24] && byte_step >= 3'd3;
  endfunction

  function automatic logic [7:0] next_tx_byte();
    logic [7:0] addr;
    addr = dev_addr & ira_pkg::ADDR_MASK;
    if (byte_step == 3'd0) return addr;
    if (byte_step == 3'd1) return held[23:16];
    if (held[24]) return (byte_step == 3'd2) ? (addr | ira_pkg::READ_BIT) : ira_pkg::FILL_BYTE;
    return (byte_step == 3'd2) ? held[15:8] : held[7:0];
  endfunction

  function automatic logic pull_for_bit();
    if (bit_cnt < 4'd8) begin
      if (reading_byte()) return 1'b0;
      return (shifter & ira_pkg::MSB_MASK) == 8'h00;
    end
    // master answers ACK after the first read byte, NACK after the last
    if (reading_byte()) return byte_step == 3'd3;
    return 1'b0;
  endfunction

  function automatic void open_byte();
    shifter   = next_tx_byte();
    bit_cnt   = '0;
    seq_phase = ira_pkg::PH_BIT_LOW;
    drive_lines(1'b0, pull_for_bit());
  endfunction

  // Close the current bus segment; return 1 when the stop completes
  function automatic logic end_segment(input logic sda);
    logic fin;
    fin = 1'b0;
    case (seq_phase)
      ira_pkg::PH_START_LOW: begin
        seq_phase = ira_pkg::PH_START_SETUP;
        drive_lines(1'b1, 1'b0);
      end
      ira_pkg::PH_START_SETUP: begin
        seq_phase = ira_pkg::PH_START_HOLD;
        drive_lines(1'b1, 1'b1);
      end
      ira_pkg::PH_START_HOLD: open_byte();
      ira_pkg::PH_BIT_LOW: begin
        seq_phase = ira_pkg::PH_BIT_HIGH;
        drive_lines(1'b1, pull_for_bit());
      end
      ira_pkg::PH_BIT_HIGH: begin
        if (bit_cnt < 4'd8) begin
          if (reading_byte()) gathered = {gathered[14:0], sda};
          shifter   = shifter << 1;
          bit_cnt   = bit_cnt + 4'd1;
          seq_phase = ira_pkg::PH_BIT_LOW;
          drive_lines(1'b0, pull_for_bit());
        end else begin
          // acknowledge slot: count a missing device ACK, then move on
          if (!reading_byte() && sda && fails < 3'd7) fails = fails + 3'd1;
          byte_step = byte_step + 3'd1;
          if (held[24] && byte_step == 3'd2) begin
            seq_phase = ira_pkg::PH_START_LOW;
            drive_lines(1'b0, 1'b0);
          end else if (byte_step >= (held[24] ? 3'd5 : 3'd4)) begin
            seq_phase = ira_pkg::PH_STOP_LOW;
            drive_lines(1'b0, 1'b1);
          end else begin
            open_byte();
          end
        end
      end
      ira_pkg::PH_STOP_LOW: begin
        seq_phase = ira_pkg::PH_STOP_HIGH;
        drive_lines(1'b1, 1'b1);
      end
      ira_pkg::PH_STOP_HIGH: begin
        seq_phase = ira_pkg::PH_STOP_END;
        drive_lines(1'b1, 1'b0);
      end
      default: begin
        seq_phase = ira_pkg::PH_IDLE;
        drive_lines(1'b1, 1'b0);
        fin = 1'b1;
      end
    endcase
    return fin;
  endfunction

  // Advance the predicted sequencer by one tick and return its result word
  function automatic ira_pkg::out_item_t step_sequencer(input ira_pkg::in_item_t it);
    ira_pkg::out_item_t r;
    logic [15:0]        span;
    logic               fin;
    span = (half_ticks == 16'd0) ? 16'd1 : half_ticks;
    fin  = 1'b0;
    if (seq_phase == ira_pkg::PH_IDLE) begin
      if (it.command_valid) begin
        held      = {it.func, it.register_pointer, it.write_word};
        byte_step = '0;
        bit_cnt   = '0;
        shifter   = '0;
        gathered  = '0;
        fails     = '0;
        divider   = '0;
        seq_phase = ira_pkg::PH_START_LOW;
        drive_lines(1'b0, 1'b0);
      end
    end else begin
      divider = divider + 16'd1;
      if (divider >= span) begin
        divider = '0;
        fin     = end_segment(it.sda_sample);
      end
    end
    r.scl_level    = scl_out;
    r.sda_pull_low = pull_out;
    r.busy_res     = seq_phase != ira_pkg::PH_IDLE;
    r.done_res     = fin;
    r.read_word    = fin ? gathered : 16'h0000;
    r.ack_failures = fin ? fails : 3'd0;
    return r;
  endfunction

  // ---- stimulus ----

  // Send one tick word; hold valid across back-to-back words
  task automatic send_tick(input ira_pkg::in_item_t it, input logic typed,
                           input ira_pkg::out_item_t typed_out);
    ira_pkg::out_item_t predicted;
    while (!steady && $urandom_range(99) < 26) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick_word  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = step_sequencer(it);
    expected_lines.push_back(typed ? typed_out : predicted);
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic settle_bus();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (expected_lines.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic sel, input logic [15:0] val);
    settle_bus();
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == SEL_ADDR) dev_addr = val[7:0];
    else half_ticks = val;
  endtask

  initial begin
    ira_pkg::in_item_t stim;
    sda_habit_t        habit;
    logic [7:0]        addr_pick;
    logic [15:0]       half_pick;
    int                ticks;

    habit = SDA_ACK_ALL;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed script
    foreach (SCRIPT[i]) begin
      case (SCRIPT[i].kind)
        ROW_CFG: write_register(SCRIPT[i].reg_sel, SCRIPT[i].reg_val);
        ROW_TICK: send_tick(SCRIPT[i].tick, SCRIPT[i].typed, SCRIPT[i].lines);
        default: begin
          send_tick(SCRIPT[i].tick, SCRIPT[i].typed, SCRIPT[i].lines);
          stim = SCRIPT[i].tick;
          stim.command_valid = 1'b0;
          while (seq_phase != ira_pkg::PH_IDLE) send_tick(stim, 1'b0, NO_LINES);
        end
      endcase
    end

    // Random ticks under changing settings; each setting lasts a fixed
    // number of ticks, so most changes land in the middle of a transfer
    for (int p = 0; p < 5; p++) begin
      addr_pick = (p == 0) ? 8'd0 : (p == 1) ? 8'd254 : 8'($urandom_range(254));
      half_pick = (p == 2) ? 16'hffff : 16'($urandom_range(2, 1));
      write_register(SEL_ADDR, {8'h00, addr_pick});
      write_register(SEL_HALF, half_pick);
      steady = (p == 3);
      ticks  = 0;
      while (ticks < ((p == 2) ? 30 : 80)) begin
        if (seq_phase == ira_pkg::PH_IDLE) begin
          habit = sda_habit_t'(2'($urandom_range(3)));
          stim.command_valid = ($urandom_range(3) == 0);
        end else begin
          stim.command_valid = ($urandom_range(7) == 0);
        end
        stim.func             = 1'($urandom_range(1));
        stim.register_pointer = 8'($urandom_range(255));
        stim.write_word       = 16'($urandom_range(65535));
        case (habit)
          SDA_ACK_ALL:    stim.sda_sample = 1'b0;
          SDA_SILENT:     stim.sda_sample = 1'b1;
          SDA_NOISE:      stim.sda_sample = 1'($urandom_range(1));
          default:        stim.sda_sample = ($urandom_range(9) == 0);
        endcase
        send_tick(stim, 1'b0, NO_LINES);
        ticks++;
        if ($urandom_range(199) == 0) settle_bus();
      end
    end
    steady = 1'b0;

    // Drain, then let the pipeline run dry
    settle_bus();
    repeat (8) @(posedge clk);
    if (bus_faults == 0 && expected_lines.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---- result side ----

  // Stall the result channel at random, except during the steady stretch
  always @(posedge clk) begin
    take_result <= steady || ($urandom_range(99) >= 26);
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : watch_results
    ira_pkg::out_item_t seen;
    ira_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = {out_ch.scl_level, out_ch.sda_pull_low, out_ch.busy_res, out_ch.done_res,
              out_ch.read_word, out_ch.ack_failures};
      if (expected_lines.size() == 0) begin
        if (bus_faults < 10) $display("unexpected result word: %p", seen);
        bus_faults++;
      end else begin
        want = expected_lines.pop_front();
        if (seen !== want) begin
          if (bus_faults < 10) begin
            $display("mismatch scl %b/%b pull %b/%b busy %b/%b done %b/%b (exp/act)",
                     want.scl_level, seen.scl_level, want.sda_pull_low, seen.sda_pull_low,
                     want.busy_res, seen.busy_res, want.done_res, seen.done_res);
            $display("  read word %h/%h ack failures %0d/%0d (exp/act)",
                     want.read_word, seen.read_word, want.ack_failures, seen.ack_failures);
          end
          bus_faults++;
        end
      end
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
sv/ira_pkg.sv
sv/ira_if.sv
sv/ira_seq.sv
sv/i2c_register_access_master.sv
tb/sv/tb.sv
